// ----- rtl/core/plmb_pkg.sv -----
// Shared types and constants for the packet loss burst monitor.
package plmb_pkg;

    // Field widths
    localparam int SEQ_W   = 64;
    localparam int CNT_W   = 48;
    localparam int BIN_W   = 32;
    localparam int SEL_W   = 14;

    // End-of-test marker carried in the sequence field
    localparam logic [SEQ_W-1:0] END_MARK = '1;

    // Output queue sizing
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // Beat kind carried on the slave tuser
    typedef enum logic {
        OP_PACKET = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    // One result beat
    typedef struct packed {
        logic [BIN_W-1:0] bin_count;
        logic             finished;
        logic [SEQ_W-1:0] highest_seq;
        logic [SEQ_W-1:0] lowest_seq;
        logic [CNT_W-1:0] out_of_order_count;
        logic [SEQ_W-1:0] lost_count;
        logic [CNT_W-1:0] received_count;
    } t_result;

endpackage

// ----- rtl/core/plmb_hist.sv -----
// Burst-length histogram: bin memory with reset sweep, read-modify-write and forwarding.
module plmb_hist #(
    parameter int MAX_BURST = 8192,
    localparam int AW = $clog2(MAX_BURST)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_bump,   // increment the bin at i_addr
    input  logic [AW-1:0]               i_addr,
    output logic [plmb_pkg::BIN_W-1:0]  o_data,   // bin value for the i_addr of the previous cycle
    output logic                        o_busy
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BURST - 1);

    logic [plmb_pkg::BIN_W-1:0] mem [MAX_BURST];

    logic                       r_clearing;
    logic [AW-1:0]              r_clr_addr;
    logic                       r_bump;
    logic [AW-1:0]              r_addr;
    logic [plmb_pkg::BIN_W-1:0] r_rd_data;
    logic                       r_fwd_valid;
    logic [AW-1:0]              r_fwd_addr;
    logic [plmb_pkg::BIN_W-1:0] r_fwd_data;

    logic [plmb_pkg::BIN_W-1:0] cur;
    logic [plmb_pkg::BIN_W-1:0] bumped;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [plmb_pkg::BIN_W-1:0] wr_data;

    // Value of the addressed bin: the write of the previous cycle missed the read
    always_comb begin
        cur    = (r_fwd_valid && (r_fwd_addr == r_addr)) ? r_fwd_data : r_rd_data;
        bumped = (cur == '1) ? cur : cur + 1'b1;
    end

    // Single write port shared by the reset sweep and bin updates
    always_comb begin
        wr_en   = r_clearing || r_bump;
        wr_addr = r_clearing ? r_clr_addr : r_addr;
        wr_data = r_clearing ? '0 : bumped;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[i_addr];
    end

    // Sweep and request tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_bump      <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            r_bump      <= i_bump;
            r_fwd_valid <= r_bump;
        end
    end

    // Payload side
    always_ff @(posedge i_clk) begin
        r_addr     <= i_addr;
        r_fwd_addr <= r_addr;
        r_fwd_data <= bumped;
    end

    assign o_data = cur;
    assign o_busy = r_clearing;

endmodule

// ----- rtl/core/packet_loss_burst_monitor_core.sv -----
// Top level of the packet loss burst monitor: sequence tracking, loss totals, result queue.
//
//  channel  | dir | tdata                                  | tuser
//  ---------+-----+----------------------------------------+-----------
//  s_axis   | in  | seq_num, too_short, bin_select (80b)   | op
//  m_axis   | out | counters, min/max, finished, bin (328b)| -
//
//  One beat per cycle while m_axis keeps up; a beat's result passes stage 1, stage 2
//  and the result queue. The sequence registers close their loop through combinational
//  logic; the histogram memory port does one read and one write per cycle, with
//  forwarding for back-to-back bins. Stalls on m_axis fill a four-entry result queue;
//  s_axis_tready drops only while the histogram is swept to zero after reset, bin 0 to
//  MAX_BURST-1, or when queue plus pipeline would exceed it.
module packet_loss_burst_monitor_core #(
    parameter int MAX_BURST = 8192
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] seq_num, [64] too_short, [78:65] bin_select, [79] zero
    input  logic [79:0]  s_axis_tdata,
    // [0] op
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [47:0] received_count, [111:48] lost_count, [159:112] out_of_order_count,
    // [223:160] lowest_seq, [287:224] highest_seq, [288] finished,
    // [320:289] bin_count, [327:321] zero
    output logic [327:0] m_axis_tdata
);

    localparam int AW = $clog2(MAX_BURST);
    localparam logic [63:0]   MAX_P1   = 64'(MAX_BURST) + 64'd1;
    localparam logic [AW-1:0] TOP_ADDR = AW'(MAX_BURST - 1);
    localparam int OUT_CNT_W = plmb_pkg::OUT_CNT_W;

    // Input fields
    plmb_pkg::t_op                 in_op;
    logic [plmb_pkg::SEQ_W-1:0]    in_seq;
    logic                          in_short;
    logic [plmb_pkg::SEL_W-1:0]    in_sel;
    logic                          s_fire;

    // Sequence tracking state
    logic [plmb_pkg::SEQ_W-1:0]    r_last, n_last;
    logic                          r_seen_first, n_seen_first;
    logic                          r_end_seen, n_end_seen;
    logic [plmb_pkg::CNT_W-1:0]    r_rx, n_rx;
    logic [plmb_pkg::CNT_W-1:0]    r_ooo, n_ooo;
    logic [plmb_pkg::SEQ_W-1:0]    r_min, n_min;
    logic [plmb_pkg::SEQ_W-1:0]    r_max, n_max;
    logic [plmb_pkg::SEQ_W-1:0]    r_loss, n_loss;

    logic                          take;
    logic                          counted;
    logic [plmb_pkg::SEQ_W:0]      diff;
    logic                          is_gap;
    logic                          sel_ok;
    logic [31:0]                   sel_m1;

    // Stage 1
    logic                          r_v1;
    logic                          r_read1;
    logic                          r_gap1;
    logic [plmb_pkg::SEQ_W-1:0]    r_diff1;
    logic [AW-1:0]                 r_sel_addr1;
    plmb_pkg::t_result             r_snap1;

    logic [plmb_pkg::SEQ_W-1:0]    diff_m1;
    logic [plmb_pkg::SEQ_W-1:0]    diff_m2;
    logic [AW-1:0]                 gap_addr;
    logic [AW-1:0]                 hist_addr;
    logic                          hist_bump;

    // Stage 2
    logic                          r_v2;
    logic                          r_gap2;
    logic                          r_read2;
    logic [plmb_pkg::SEQ_W-1:0]    r_gap_len2;
    plmb_pkg::t_result             r_snap2;

    logic [plmb_pkg::SEQ_W:0]      loss_sum;
    logic [plmb_pkg::BIN_W-1:0]    hist_data;
    logic                          hist_busy;
    plmb_pkg::t_result             result;

    // Result queue
    plmb_pkg::t_result             q_mem [plmb_pkg::OUT_DEPTH];
    logic [plmb_pkg::OUT_PTR_W-1:0] r_wr_ptr;
    logic [plmb_pkg::OUT_PTR_W-1:0] r_rd_ptr;
    logic [plmb_pkg::OUT_CNT_W-1:0] r_cnt;
    logic [plmb_pkg::OUT_CNT_W:0]   in_flight;
    logic                          m_fire;
    plmb_pkg::t_result             q_head;

    // Field unpacking
    assign in_op    = plmb_pkg::t_op'(s_axis_tuser);
    assign in_seq   = s_axis_tdata[63:0];
    assign in_short = s_axis_tdata[64];
    assign in_sel   = s_axis_tdata[78:65];
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign m_fire   = m_axis_tvalid && m_axis_tready;

    // Beat classification against the last in-order sequence
    always_comb begin
        take    = s_fire && (in_op == plmb_pkg::OP_PACKET) && !in_short && !r_end_seen;
        counted = take && (in_seq != plmb_pkg::END_MARK);
        diff    = {1'b0, in_seq} - {1'b0, r_last};
        is_gap  = r_seen_first && !diff[plmb_pkg::SEQ_W]
                  && (diff[plmb_pkg::SEQ_W-1:0] > 64'd1);
        sel_ok  = (in_sel != '0) && (32'(in_sel) <= 32'(MAX_BURST));
        sel_m1  = 32'(in_sel) - 32'd1;
    end

    // Next sequence state
    always_comb begin
        n_last       = r_last;
        n_seen_first = r_seen_first;
        n_end_seen   = r_end_seen;
        n_rx         = r_rx;
        n_ooo        = r_ooo;
        n_min        = r_min;
        n_max        = r_max;
        if (take && (in_seq == plmb_pkg::END_MARK)) begin
            n_end_seen = 1'b1;
        end
        if (counted) begin
            n_rx = (r_rx == '1) ? r_rx : r_rx + 1'b1;
            if (in_seq < r_min) begin
                n_min = in_seq;
            end
            if (in_seq > r_max) begin
                n_max = in_seq;
            end
            if (!r_seen_first) begin
                n_seen_first = 1'b1;
                n_last       = in_seq;
            end else if ((diff == 65'd1) || is_gap) begin
                n_last = in_seq;
            end else begin
                n_ooo = (r_ooo == '1) ? r_ooo : r_ooo + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last       <= '0;
            r_seen_first <= 1'b0;
            r_end_seen   <= 1'b0;
            r_rx         <= '0;
            r_ooo        <= '0;
            r_min        <= '1;
            r_max        <= '0;
        end else begin
            r_last       <= n_last;
            r_seen_first <= n_seen_first;
            r_end_seen   <= n_end_seen;
            r_rx         <= n_rx;
            r_ooo        <= n_ooo;
            r_min        <= n_min;
            r_max        <= n_max;
        end
    end

    // Stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= s_fire;
        end
        r_read1     <= (in_op == plmb_pkg::OP_READ) && sel_ok;
        r_gap1      <= counted && is_gap;
        r_diff1     <= diff[plmb_pkg::SEQ_W-1:0];
        r_sel_addr1 <= sel_m1[AW-1:0];
        r_snap1.received_count     <= n_rx;
        r_snap1.lost_count         <= '0;
        r_snap1.out_of_order_count <= n_ooo;
        r_snap1.lowest_seq         <= n_min;
        r_snap1.highest_seq        <= n_max;
        r_snap1.finished           <= n_end_seen;
        r_snap1.bin_count          <= '0;
    end

    // Gap length and clamped bin address
    always_comb begin
        diff_m1   = r_diff1 - 64'd1;
        diff_m2   = r_diff1 - 64'd2;
        gap_addr  = (r_diff1 > MAX_P1) ? TOP_ADDR : diff_m2[AW-1:0];
        hist_addr = r_gap1 ? gap_addr : r_sel_addr1;
        hist_bump = r_v1 && r_gap1;
    end

    plmb_hist #(
        .MAX_BURST (MAX_BURST)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bump  (hist_bump),
        .i_addr  (hist_addr),
        .o_data  (hist_data),
        .o_busy  (hist_busy)
    );

    // Stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_gap2     <= r_gap1;
        r_read2    <= r_read1;
        r_gap_len2 <= diff_m1;
        r_snap2    <= r_snap1;
    end

    // Loss accumulation, saturating
    always_comb begin
        loss_sum = {1'b0, r_loss} + {1'b0, r_gap_len2};
        n_loss   = r_loss;
        if (r_v2 && r_gap2) begin
            n_loss = loss_sum[plmb_pkg::SEQ_W] ? '1 : loss_sum[plmb_pkg::SEQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss <= '0;
        end else begin
            r_loss <= n_loss;
        end
    end

    // Finished result
    always_comb begin
        result            = r_snap2;
        result.lost_count = n_loss;
        result.bin_count  = r_read2 ? hist_data : '0;
    end

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_v2) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (m_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + OUT_CNT_W'(r_v2) - OUT_CNT_W'(m_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            q_mem[r_wr_ptr] <= result;
        end
    end

    // Space check covers beats still in the pipeline
    always_comb begin
        in_flight = {1'b0, r_cnt} + (OUT_CNT_W + 1)'(r_v1) + (OUT_CNT_W + 1)'(r_v2);
        s_axis_tready = !hist_busy && (in_flight < (OUT_CNT_W + 1)'(plmb_pkg::OUT_DEPTH));
    end

    assign q_head        = q_mem[r_rd_ptr];
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {7'd0, q_head};

`ifndef SYNTHESIS
    // Nothing moves while the histogram sweep runs
    a_idle_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_busy |-> (!r_v1 && !r_v2 && (r_cnt == '0)))
        else $error("pipeline active during histogram sweep");

    // Queue plus pipeline never exceeds queue depth
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_flight <= (OUT_CNT_W + 1)'(plmb_pkg::OUT_DEPTH))
        else $error("result queue overcommitted");

    // An accepted beat enters stage 1 next cycle
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_v1)
        else $error("accepted beat lost");

    // Once a packet counted, minimum never exceeds maximum
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_first |-> (r_min <= r_max))
        else $error("sequence minimum above maximum");
`endif

endmodule
